@@ rtl/core/dle_shielded_voice_deframer_core_defines.svh @@
// ----------------------------------------------------------------------------
// dle_shielded_voice_deframer_core_defines.svh
// Assertion macros shared by the deframer core modules.
// ----------------------------------------------------------------------------
`ifndef DLE_SHIELDED_VOICE_DEFRAMER_CORE_DEFINES_SVH
`define DLE_SHIELDED_VOICE_DEFRAMER_CORE_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define DSVD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DSVD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/dsvd_pkg.sv @@
// ----------------------------------------------------------------------------
// dsvd_pkg
// Types, byte codes and the escape code decoder for the voice deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package dsvd_pkg;

	localparam logic [7:0] BYTE_DLE   = 8'h10;
	localparam logic [7:0] BYTE_ETX   = 8'h03;
	localparam logic [7:0] BYTE_SUB   = 8'h1A;
	localparam logic [7:0] BYTE_DC4   = 8'h14;
	localparam logic [7:0] BYTE_TMARK = 8'h54;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [0:0] {
		OP_BYTE    = 1'b0,
		OP_RESTART = 1'b1
	} dsvd_op_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EVENT = 2'd1,
		KIND_END   = 2'd2
	} dsvd_kind_t;

	typedef enum logic [4:0] {
		EV_DTMF      = 5'd0,
		EV_BONG      = 5'd1,
		EV_DATAFAX   = 5'd2,
		EV_BUSY      = 5'd3,
		EV_FAXCALL   = 5'd4,
		EV_DIAL      = 5'd5,
		EV_DATACALL  = 5'd6,
		EV_ONHOOK    = 5'd7,
		EV_OFFHOOK   = 5'd8,
		EV_LOOPBREAK = 5'd9,
		EV_SIT       = 5'd10,
		EV_POLARITY  = 5'd11,
		EV_SILENCE   = 5'd12,
		EV_RINGBACK  = 5'd13,
		EV_RING      = 5'd14,
		EV_NOENERGY  = 5'd15,
		EV_TDD       = 5'd16,
		EV_VOICE     = 5'd17,
		EV_WAITING   = 5'd18,
		EV_ABORT     = 5'd19,
		EV_NOTICE    = 5'd20,
		EV_UNKNOWN   = 5'd21
	} dsvd_event_t;

	typedef struct packed {
		dsvd_op_t   op;
		logic [7:0] byte_in;
	} dsvd_item_t;

	typedef struct packed {
		dsvd_kind_t  kind;
		logic [7:0]  value;
		dsvd_event_t event_code;
		logic        last;
	} dsvd_result_t;

	// Classified work for the back end; dup emits the data byte twice.
	typedef struct packed {
		dsvd_kind_t  kind;
		logic [7:0]  value;
		dsvd_event_t event_code;
		logic        dup;
	} dsvd_cmd_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} dsvd_qstat_t;

	function automatic dsvd_event_t dsvd_classify(input logic [7:0] code);
		dsvd_event_t ev;
		ev = EV_UNKNOWN;
		unique case (code)
			8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
			8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
			8'h41, 8'h42, 8'h43, 8'h44,
			8'h2A, 8'h23:                       ev = EV_DTMF;      // 0-9 A-D * #
			8'h24:                              ev = EV_BONG;      // $
			8'h61:                              ev = EV_DATAFAX;   // a
			8'h62, 8'h4B:                       ev = EV_BUSY;      // b K
			8'h63, 8'h6D:                       ev = EV_FAXCALL;   // c m
			8'h64, 8'h69:                       ev = EV_DIAL;      // d i
			8'h65, 8'h66:                       ev = EV_DATACALL;  // e f
			8'h68, 8'h70:                       ev = EV_ONHOOK;    // h p
			8'h48, 8'h50:                       ev = EV_OFFHOOK;   // H P
			8'h49:                              ev = EV_LOOPBREAK; // I
			8'h4A:                              ev = EV_SIT;       // J
			8'h4C:                              ev = EV_POLARITY;  // L
			8'h71:                              ev = EV_SILENCE;   // q
			8'h72:                              ev = EV_RINGBACK;  // r
			8'h52:                              ev = EV_RING;      // R
			8'h73:                              ev = EV_NOENERGY;  // s
			8'h74:                              ev = EV_TDD;       // t
			8'h76, 8'h56:                       ev = EV_VOICE;     // v V
			8'h77:                              ev = EV_WAITING;   // w
			BYTE_DC4:                           ev = EV_ABORT;
			8'h2F, 8'h7E, 8'h45, 8'h6F,
			8'h51, 8'h53, 8'h75, 8'h59:         ev = EV_NOTICE;    // / ~ E o Q S u Y
			default:                            ev = EV_UNKNOWN;
		endcase
		return ev;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/dle_shielded_voice_deframer_core.sv @@
// ----------------------------------------------------------------------------
// dle_shielded_voice_deframer_core
// Voice modem receive deframer: DLE unstuffing and escape code events.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one line byte (op = byte) or a restart (op = restart) per
//   transfer. result channel: audio data bytes, numbered events and the
//   end-of-stream marker, with last set on the final result of an item.
//   An item's result is written into the command queue and then loaded
//   into the output register. Throughput: one item per cycle while the queue
//   is not full; DLE SUB yields two results and so takes two transfers.
//   A four-entry command queue sits between the classifier and the output
//   register; the item channel stalls only while that queue is full, so
//   items keep flowing while a result waits.
//   Bytes that give no result (DLE, timing mark, bytes after end of stream,
//   restarts) take no queue entry.
//   Reset clears the escape and end-of-stream flags and empties the queue.
//   While the receiver stalls, the result payload holds.
// ----------------------------------------------------------------------------
`default_nettype none

module dle_shielded_voice_deframer_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    item_valid,
	output logic                   item_stall,
	input  dsvd_pkg::dsvd_item_t   item,
	output logic                   result_valid,
	input  wire                    result_stall,
	output dsvd_pkg::dsvd_result_t result
);
	import dsvd_pkg::*;

	dsvd_qstat_t qstat;
	dsvd_cmd_t   push_cmd;
	dsvd_cmd_t   head;
	logic        push;
	logic        pop;

	dsvd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.qstat      (qstat),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	dsvd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	dsvd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

@@ rtl/core/dsvd_front.sv @@
// ----------------------------------------------------------------------------
// dsvd_front
// Accepts line bytes, tracks escape and end-of-stream, and classifies
// each byte that gives a result into a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dsvd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_stall,
	input  dsvd_pkg::dsvd_item_t item,
	input  dsvd_pkg::dsvd_qstat_t qstat,
	output logic                push,
	output dsvd_pkg::dsvd_cmd_t push_cmd
);
	import dsvd_pkg::*;

	logic accept;
	logic esc_q, ended_q;
	logic esc_d, ended_d;
	logic want_push;

	assign item_stall = qstat.full;
	assign accept     = item_valid && !item_stall;
	assign push       = accept && want_push;

	always_comb begin
		esc_d               = esc_q;
		ended_d             = ended_q;
		want_push           = 1'b0;
		push_cmd.kind       = KIND_DATA;
		push_cmd.value      = item.byte_in;
		push_cmd.event_code = EV_DTMF;
		push_cmd.dup        = 1'b0;
		if (item.op == OP_RESTART) begin
			esc_d   = 1'b0;
			ended_d = 1'b0;
		end else if (ended_q) begin
			// drop bytes until restart
		end else if (!esc_q) begin
			if (item.byte_in == BYTE_DLE) begin
				esc_d = 1'b1;
			end else begin
				want_push = 1'b1;
			end
		end else begin
			esc_d = 1'b0;
			unique case (item.byte_in)
				BYTE_DLE: begin
					want_push = 1'b1;
				end
				BYTE_SUB: begin
					want_push      = 1'b1;
					push_cmd.value = BYTE_DLE;
					push_cmd.dup   = 1'b1;
				end
				BYTE_ETX: begin
					want_push     = 1'b1;
					ended_d       = 1'b1;
					push_cmd.kind = KIND_END;
				end
				BYTE_TMARK: begin
					want_push = 1'b0;
				end
				default: begin
					want_push           = 1'b1;
					push_cmd.kind       = KIND_EVENT;
					push_cmd.event_code = dsvd_classify(item.byte_in);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= 1'b0;
			ended_q <= 1'b0;
		end else if (accept) begin
			esc_q   <= esc_d;
			ended_q <= ended_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/dsvd_queue.sv @@
// ----------------------------------------------------------------------------
// dsvd_queue
// Short command queue between the classifier and the result stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dle_shielded_voice_deframer_core_defines.svh"

module dsvd_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  dsvd_pkg::dsvd_cmd_t  push_cmd,
	input  wire                  pop,
	output dsvd_pkg::dsvd_cmd_t  head,
	output dsvd_pkg::dsvd_qstat_t qstat
);
	import dsvd_pkg::*;

	dsvd_cmd_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign qstat.full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.nonempty = (cnt_q != '0);
	assign head           = entry_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		n = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`DSVD_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count over depth")
	`DSVD_ASSERT_IMPL(a_no_overflow, push, !qstat.full, "push into full queue")
	`DSVD_ASSERT_IMPL(a_no_underflow, pop, qstat.nonempty, "pop from empty queue")

endmodule

`default_nettype wire

@@ rtl/core/dsvd_back.sv @@
// ----------------------------------------------------------------------------
// dsvd_back
// Turns queued commands into result transfers through an output register;
// a doubled escape byte takes two transfers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dle_shielded_voice_deframer_core_defines.svh"

module dsvd_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  dsvd_pkg::dsvd_cmd_t   head,
	input  dsvd_pkg::dsvd_qstat_t qstat,
	output logic                  pop,
	output logic                  result_valid,
	input  wire                   result_stall,
	output dsvd_pkg::dsvd_result_t result
);
	import dsvd_pkg::*;

	logic         valid_q;
	dsvd_result_t result_q;
	logic         phase_q;
	logic         load;
	logic         final_one;

	assign load         = qstat.nonempty && (!valid_q || !result_stall);
	assign final_one    = !head.dup || phase_q;
	assign pop          = load && final_one;
	assign result_valid = valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
			// advance to the second copy, then back
			if (load && head.dup) begin
				phase_q <= !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.kind       <= head.kind;
			result_q.value      <= head.value;
			result_q.event_code <= head.event_code;
			result_q.last       <= final_one;
		end
	end

	`DSVD_ASSERT_IMPL(a_phase_has_head, phase_q, qstat.nonempty && head.dup,
		"second copy pending without its command")
	`DSVD_ASSERT_IMPL(a_first_copy_dle, valid_q && !result_q.last,
		result_q.kind == KIND_DATA && result_q.value == BYTE_DLE,
		"non-final result is not a DLE data byte")
	`DSVD_ASSERT_IMPL(a_dup_is_dle, qstat.nonempty && head.dup,
		head.kind == KIND_DATA && head.value == BYTE_DLE,
		"doubled command is not a DLE data byte")

endmodule

`default_nettype wire
